FILE: design/emb_pkg.sv
// Shared types and constants for the emboss pixel stream block.
// No dependencies; imported by every design file except emb_ram.
`default_nettype none

package emb_pkg;

  // Frame geometry register widths and reset values
  localparam int unsigned WIDTH_REG_BITS  = 13;
  localparam int unsigned HEIGHT_REG_BITS = 16;
  localparam int unsigned CFG_DATA_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS    = 4;
  localparam int unsigned DEF_MAX_WIDTH   = 4096;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd480;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 4'd1;

  localparam int unsigned PIXEL_BITS = 32;
  localparam int unsigned RGB_BITS   = 24;

  localparam logic [7:0] GRAY_MID = 8'd128;
  localparam logic [7:0] GRAY_MAX = 8'hFF;

  // One classified request between front and back
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic [RGB_BITS-1:0]   upper_left;
    logic                  border;
    logic                  frame_last;
  } emb_item_t;

endpackage

`default_nettype wire

FILE: design/emboss_pixel_stream.sv
// Emboss filter on a raster RGBA stream. A pixel accepted at one edge is written to
// the queue slot; the back pops it into the result register that drives the ports.
// Throughput: one pixel per cycle while pops keep up (one line buffer read + write
// each); a stalled pop backs up into a two-entry queue, then raises in_full.
// Reset (rst_n, sync, active low): counters to frame origin, width 640, height 480,
// queue and result register emptied; line buffer not cleared, written before read.
`default_nettype none

module emboss_pixel_stream
  import emb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration write channel; always ready
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  // pixel input, queue-style
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic [PIXEL_BITS-1:0]    in_pixel,
  // result output, queue-style
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic [PIXEL_BITS-1:0]         out_pixel,
  output logic                          out_frame_last
);

  emb_item_t q_in_item, q_head;
  logic      q_push, q_full, q_valid, q_pop, out_valid;

  assign cfg_ready = 1'b1;

  // Front: position tracking and line buffer. The upper-left neighbour of a
  // pixel is the entry read while the previous pixel was accepted.
  emb_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (in_push),
    .pixel     (in_pixel),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  // Decoupling queue: the input only stalls when two requests are held.
  emb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Back: channel difference selection, saturation and result register.
  emb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_valid      (out_valid),
    .out_pixel      (out_pixel),
    .out_frame_last (out_frame_last)
  );

  assign in_full   = q_full;
  assign out_empty = !out_valid;

endmodule

`default_nettype wire

FILE: design/emb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old contents when reading and writing the same address.
`default_nettype none

module emb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem_r[rd_addr];
    end
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/emb_front.sv
// Front end: config registers, raster position counters and the line buffer.
// Uses emb_pkg and emb_ram; emits one classified request per accepted pixel.
`default_nettype none

module emb_front
  import emb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     push,
  input  wire logic [PIXEL_BITS-1:0]    pixel,
  input  wire logic                     q_full,
  output logic                          q_push,
  output emb_item_t                     q_item
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  // compare width covers both the register and MAX_WIDTH itself
  localparam int unsigned CW = (WIDTH_REG_BITS > AW + 1) ? WIDTH_REG_BITS : AW + 1;

  logic [WIDTH_REG_BITS-1:0]  image_width_r;
  logic [HEIGHT_REG_BITS-1:0] image_height_r;
  logic [AW-1:0]              col_r, col_nxt;
  logic [HEIGHT_REG_BITS-1:0] row_r, row_nxt;

  logic [CW-1:0]              w_eff;
  logic [HEIGHT_REG_BITS-1:0] h_eff;
  logic                       last_col, last_row, accept;
  logic [RGB_BITS-1:0]        ul_rgb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = CW'(image_width_r);
    if (image_width_r == '0) begin
      w_eff = CW'(1);
    end else if (w_eff > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end
    h_eff = (image_height_r == '0) ? HEIGHT_REG_BITS'(1) : image_height_r;
  end

  assign accept   = push && !q_full;
  assign last_col = (CW'(col_r) + CW'(1)) >= w_eff;
  assign last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, h_eff};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + HEIGHT_REG_BITS'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Read old entry and overwrite it in the same cycle; the read data
  // then holds the upper-left neighbour for the next pixel.
  emb_ram #(
    .WIDTH (RGB_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .we      (accept),
    .wr_addr (col_r),
    .wr_data (pixel[PIXEL_BITS-1:8]),
    .re      (accept),
    .rd_addr (col_r),
    .rd_data (ul_rgb)
  );

  assign q_push = accept;

  always_comb begin
    q_item.pixel      = pixel;
    q_item.upper_left = ul_rgb;
    q_item.border     = (col_r == '0) || (row_r == '0);
    q_item.frame_last = last_col && last_row;
  end

endmodule

`default_nettype wire

FILE: design/emb_queue.sv
// Two-entry queue of classified requests between front and back.
// Uses emb_pkg for the request type.
`default_nettype none

module emb_queue
  import emb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire emb_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           valid,
  output emb_item_t      head
);

  emb_item_t  slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign full  = count_r == 2'd2;
  assign valid = count_r != 2'd0;
  assign head  = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

FILE: design/emb_back.sv
// Back end: emboss arithmetic and the result register.
// Uses emb_pkg; drains the request queue into a one-deep output stage.
`default_nettype none

module emb_back
  import emb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire emb_item_t             q_head,
  output logic                       q_pop,
  input  wire logic                  out_pop,
  output logic                       out_valid,
  output logic [PIXEL_BITS-1:0]      out_pixel,
  output logic                       out_frame_last
);

  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_pixel_r;
  logic                  out_last_r;

  logic signed [8:0] dr, dg, db, pick;
  logic [8:0]        ar, ag, ab, best;
  logic signed [9:0] sum;
  logic [7:0]        gray;

  function automatic logic [8:0] mag(input logic signed [8:0] d);
    mag = d[8] ? 9'(-d) : 9'(d);
  endfunction

  always_comb begin
    dr = $signed({1'b0, q_head.upper_left[23:16]}) - $signed({1'b0, q_head.pixel[31:24]});
    dg = $signed({1'b0, q_head.upper_left[15:8]})  - $signed({1'b0, q_head.pixel[23:16]});
    db = $signed({1'b0, q_head.upper_left[7:0]})   - $signed({1'b0, q_head.pixel[15:8]});
    ar = mag(dr);
    ag = mag(dg);
    ab = mag(db);
    // ties favour red, then green
    pick = dr;
    best = ar;
    if (ag > best) begin
      pick = dg;
      best = ag;
    end
    if (ab > best) begin
      pick = db;
    end
    sum = $signed({2'b00, GRAY_MID}) + 10'(pick);
    if (q_head.border) begin
      gray = GRAY_MID;
    end else if (sum[9]) begin
      gray = '0;
    end else if (sum[8]) begin
      gray = GRAY_MAX;
    end else begin
      gray = sum[7:0];
    end
  end

  assign q_pop = q_valid && (!out_valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_pixel_r <= {gray, gray, gray, q_head.pixel[7:0]};
      out_last_r  <= q_head.frame_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

FILE: dv/emboss_pixel_stream_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for emboss_pixel_stream: drives frames, predicts gray per pixel.
// Depends on emb_pkg and the emboss_pixel_stream design only.

module emboss_pixel_stream_tb;
  import emb_pkg::*;

  // Spare register indexes; writes to them must leave the geometry alone
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 4'hF;

  localparam int QUIET_LIMIT  = 500;  // cycles with no request moving on any channel
  localparam int SETTLE_TAIL  = 10;   // cycles after the last result, to catch strays
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 780;
  localparam int CALM_AFTER   = 640;  // random items before the idle-free tail

  // Hand-built 4x3 frame; each inner pixel hits one corner of the difference logic
  localparam logic [PIXEL_BITS-1:0] GRID [12] = '{
    32'hFFFFFF00, 32'h00000011, 32'h80808022, 32'h12345633,
    32'h10203044, 32'h000000FF, 32'hFF102055, 32'h857B8066,
    32'hABCDEF77, 32'h10302088, 32'h01022899, 32'hFF1020AA
  };

  typedef struct {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_last;
  } emboss_out_t;

  // Tracks frame position, line buffer and geometry; queues the gray pixels owed.
  class emboss_tracker;
    logic [WIDTH_REG_BITS-1:0]  width_reg;
    logic [HEIGHT_REG_BITS-1:0] height_reg;
    logic [RGB_BITS-1:0]        line_rgb [DEF_MAX_WIDTH];
    logic [RGB_BITS-1:0]        ul_hold;
    int unsigned                col;
    int unsigned                row;
    emboss_out_t                gray_due [$];
    int                         faults;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      ul_hold    = '0;
      col        = 0;
      row        = 0;
      faults     = 0;
      foreach (line_rgb[i]) line_rgb[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_REG_BITS-1:0];
      else if (idx == REG_IMAGE_HEIGHT) height_reg = val[HEIGHT_REG_BITS-1:0];
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // Pixels still needed to close the current frame, counting shrunken sizes
    function int unsigned to_frame_end();
      int unsigned w;
      int unsigned h;
      int unsigned rest;
      w    = eff_width();
      h    = eff_height();
      rest = (col + 1 >= w) ? 1 : w - col;
      if (row + 1 < h) rest += (h - 1 - row) * w;
      return rest;
    endfunction

    // Biggest-magnitude channel difference (upper-left minus current), red wins ties
    function logic [7:0] emboss_gray(logic [RGB_BITS-1:0] cur, logic [RGB_BITS-1:0] ul);
      int d;
      int pick;
      int best;
      int v;
      pick = 0;
      best = -1;
      for (int b = 0; b < 3; b++) begin
        d = int'(ul[(2-b)*8 +: 8]) - int'(cur[(2-b)*8 +: 8]);
        if ((d < 0 ? -d : d) > best) begin
          pick = d;
          best = (d < 0) ? -d : d;
        end
      end
      v = int'(GRAY_MID) + pick;
      if (v < 0) return 8'd0;
      if (v > int'(GRAY_MAX)) return GRAY_MAX;
      return v[7:0];
    endfunction

    function void accept_pixel(logic [PIXEL_BITS-1:0] p);
      int unsigned         w;
      int unsigned         h;
      int unsigned         slot;
      logic [RGB_BITS-1:0] ul;
      logic [7:0]          g;
      logic                last_col;
      logic                last_row;
      emboss_out_t         res;
      w    = eff_width();
      h    = eff_height();
      slot = (col >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col;
      ul   = ul_hold;
      ul_hold        = line_rgb[slot];
      line_rgb[slot] = p[31:8];
      g = (row == 0 || col == 0) ? GRAY_MID : emboss_gray(p[31:8], ul);
      last_col = (col + 1 >= w);
      last_row = (row + 1 >= h);
      res.pixel      = {g, g, g, p[7:0]};
      res.frame_last = last_col && last_row;
      gray_due.push_back(res);
      if (last_col) begin
        col = 0;
        row = last_row ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void check_pixel(logic [PIXEL_BITS-1:0] got_pixel, logic got_last);
      emboss_out_t want;
      if (gray_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("unexpected result: pixel %h last %b", got_pixel, got_last);
        return;
      end
      want = gray_due.pop_front();
      if (got_pixel !== want.pixel || got_last !== want.frame_last) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("mismatch: expected pixel %h last %b, got pixel %h last %b",
                   want.pixel, want.frame_last, got_pixel, got_last);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic [PIXEL_BITS-1:0]    in_pixel = '0;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic [PIXEL_BITS-1:0]    out_pixel;
  logic                     out_frame_last;

  emboss_tracker tracker = new();
  bit            calm = 1'b0;   // set for the idle-free tail of the run
  int            pixels_sent = 0;
  int            pop_stall = 0;
  int            quiet_cycles = 0;

  emboss_pixel_stream DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_pixel      (in_pixel),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_pixel     (out_pixel),
    .out_frame_last(out_frame_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check every popped request, and hold pop low in random bursts.
  // Outputs are read in the active region of the edge, i.e. their pre-edge values.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      tracker.check_pixel(out_pixel, out_frame_last);
    if (pop_stall > 0) begin
      pop_stall--;
      out_pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop_stall = $urandom_range(0, 10);  // further low-pop cycles after this one
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Watchdog: any request moving on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Writes one register; cfg_valid is left high so back-to-back writes never
  // lower and raise it in one step. The caller drops it after the group.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_BITS-1:0] w,
                              input logic [CFG_DATA_BITS-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // One pixel request, sometimes after a random gap. push stays high on return
  // so consecutive pixels go in on consecutive edges while in_full stays low.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] p);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_full);
    tracker.accept_pixel(p);
    pixels_sent++;
  endtask

  // Mostly random bits, but a third of pixels get 00/80/FF colour bytes so
  // clamping and tied differences turn up often.
  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    logic [PIXEL_BITS-1:0] p;
    int                    b;
    p = $urandom;
    if ($urandom_range(0, 2) == 0)
      for (b = 1; b < 4; b++)
        case ($urandom_range(0, 3))
          0: p[b*8 +: 8] = 8'h00;
          1: p[b*8 +: 8] = GRAY_MAX;
          2: p[b*8 +: 8] = GRAY_MID;
          default: ;
        endcase
    return p;
  endfunction

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // Stop pushing and wait for every owed result; the block is then idle
  task automatic drain();
    in_push <= 1'b0;
    while (tracker.gray_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int          random_base;
    int unsigned w;
    int unsigned h;
    int unsigned k;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: border, clamp high/low, red-green tie, green-blue tie, blue wins, zero
    set_geometry(16'd4, 16'd3);
    foreach (GRID[i]) send_pixel(GRID[i]);
    drain();

    // Zero width and height act as 1; spare bits above the width field are dropped
    set_geometry(16'hE000, 16'd0);
    send_pixel(32'h00000000);
    send_pixel(32'hFFFFFFFF);
    send_pixel(rand_pixel());
    drain();

    // Out-of-range register indexes are ignored: still a 1x1 frame afterwards
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0001);
    cfg_valid <= 1'b0;
    send_random(2);
    drain();

    // Oversized width clips to the line buffer depth, one-row frame; then a
    // width shrink mid-row leaves the column counter past the new last column
    set_geometry(16'hFFFF, 16'd0);
    send_random(40);
    drain();
    set_geometry(16'd8, 16'd0);
    send_random(tracker.to_frame_end());
    drain();

    // Full row then part of a second, then shrink the width mid-row so the
    // column counter sits beyond the new last column and wraps
    set_geometry(16'd24, 16'd2);
    send_random(24 + 10);
    drain();
    set_geometry(16'd5, 16'd2);
    send_random(tracker.to_frame_end());
    drain();

    // Tallest frame, cut short by a height shrink past the current row
    set_geometry(16'd3, 16'hFFFF);
    send_random(3 * 20 + 1);
    drain();
    set_geometry(16'd3, 16'd2);
    send_random(tracker.to_frame_end());
    drain();

    // Random frames; every phase starts and ends on a frame boundary. Width only
    // grows at the frame origin, so no line buffer entry is read unwritten.
    random_base = pixels_sent;
    while (pixels_sent - random_base < RANDOM_ITEMS) begin
      if (pixels_sent - random_base >= CALM_AFTER) calm = 1'b1;
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 7) == 0) w = 0;
        if ($urandom_range(0, 7) == 0) h = 0;
        // junk in bits above the width field must be ignored
        set_geometry(16'(w) | (16'($urandom_range(0, 7)) << WIDTH_REG_BITS), 16'(h));
        send_random(tracker.to_frame_end());
      end else begin
        // partial frame, then shrink while mid-frame and finish it
        w = $urandom_range(2, 16);
        h = $urandom_range(2, 8);
        set_geometry(16'(w), 16'(h));
        k = $urandom_range(1, w * h - 1);
        send_random(k);
        drain();
        set_geometry(16'($urandom_range(0, w)), 16'($urandom_range(0, h)));
        send_random(tracker.to_frame_end());
      end
      drain();
    end

    in_push <= 1'b0;
    while (tracker.gray_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
    if (tracker.faults == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
